### hw/rtl/rple_pkg.sv
// Package for the register patch list engine.
// Holds the sequencer and phase types, operation and item codes, and the list entry layout.
// No dependencies.
package rple_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_READ,
    ST_ADD_CMP,
    ST_RUN_READ,
    ST_RUN_ENTRY,
    ST_RUN_VERIFY
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OLD,
    PH_BACK
  } phase_t;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ETYPE_PLAIN    = 2'd0;
  localparam logic [1:0] ETYPE_MASKED   = 2'd1;
  localparam logic [1:0] ETYPE_NOVERIFY = 2'd2;

  localparam int CNT_WR   = 0;
  localparam int CNT_SKIP = 1;
  localparam int CNT_OK   = 2;
  localparam int CNT_BAD  = 3;
  localparam int CNT_UNV  = 4;
  localparam int NUM_CNT  = 5;

  localparam logic [31:0] LOW_HALF = 32'h0000_ffff;
  localparam logic [15:0] DROP_MAX = 16'hffff;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] clr;
    logic [31:0] set;
    logic [31:0] mask;
    logic [1:0]  etype;
    logic        mc;
  } entry_t;

endpackage

### hw/rtl/register_patch_list_engine.sv
// Register patch list engine: keeps the patch list in a local memory and replays it on a bus.
// Depends on rple_pkg.
// Add: reads and compares each entry in turn and merges into the first match;
// with no match it appends, or counts a drop when the list is full.
// Start and returned read data: walk the list entry by entry, one result a cycle at most;
// busy drops while a bus read is outstanding so the data can come back as a request.
// Reset clears the control state and counters; list contents are undefined until added.
module register_patch_list_engine #(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] reg_address,
  input  logic [31:0] clear_bits,
  input  logic [31:0] set_bits,
  input  logic [31:0] compare_mask,
  input  logic [1:0]  entry_kind,
  input  logic        multicast_flag,
  input  logic        verify_enable,
  input  logic [31:0] read_data,
  output logic        valid,
  output logic [1:0]  bus_op,
  output logic [31:0] bus_address,
  output logic [31:0] bus_write_data,
  output logic [5:0]  written_count,
  output logic [5:0]  skipped_count,
  output logic [5:0]  verified_count,
  output logic [5:0]  mismatched_count,
  output logic [5:0]  unverifiable_count,
  output logic [15:0] overflow_count,
  output logic        last
);
  import rple_pkg::*;

  localparam int IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CntW = $clog2(LIST_DEPTH + 1);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] cursor, cursor_next;
  logic [CntW-1:0] scan_idx, scan_next;
  logic [15:0] dropped, dropped_next;
  logic pass_verify, pass_verify_next;
  logic [5:0] cnt [NUM_CNT];
  logic [NUM_CNT-1:0] bump;
  logic cnt_clear;

  entry_t mem [LIST_DEPTH];
  entry_t rd_data, wr_data, item, item_in, merged;
  logic rd_en, wr_en, item_load;
  logic [IdxW-1:0] rd_idx, wr_idx;

  logic emit;
  logic [1:0] emit_op;
  logic [31:0] emit_addr, emit_data;

  logic accept, cur_valid, needs_old, do_check, hit, scan_end, full;
  logic [31:0] old_val, want;
  logic old_diff, back_ok;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cur_valid = (cursor < count);
  assign needs_old = (rd_data.etype != ETYPE_MASKED) && (rd_data.clr != '0);
  assign do_check  = pass_verify && (rd_data.mask != '0);
  assign hit       = (rd_data.addr == item.addr) && (rd_data.mc == item.mc);
  assign scan_end  = (scan_idx == count);
  assign full      = (count == CntW'(LIST_DEPTH));
  assign old_val   = (read_data & ~rd_data.clr) | rd_data.set;
  assign old_diff  = (old_val != read_data);
  assign want      = (rd_data.etype == ETYPE_MASKED) ? (rd_data.set & LOW_HALF) : rd_data.set;
  assign back_ok   = (((read_data ^ want) & rd_data.mask) == '0);

  always_comb begin
    item_in.addr  = reg_address;
    item_in.clr   = clear_bits;
    item_in.set   = set_bits;
    item_in.mask  = compare_mask;
    item_in.etype = (entry_kind == ETYPE_MASKED || entry_kind == ETYPE_NOVERIFY) ?
                    entry_kind : ETYPE_PLAIN;
    item_in.mc    = multicast_flag;
  end

  always_comb begin
    merged.addr  = rd_data.addr;
    merged.clr   = rd_data.clr | item.clr;
    merged.set   = (rd_data.set & ~item.clr) | item.set;
    merged.mask  = rd_data.mask | item.mask;
    merged.etype = (item.etype == ETYPE_NOVERIFY) ? ETYPE_NOVERIFY : rd_data.etype;
    merged.mc    = rd_data.mc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_ADD:   if (phase == PH_IDLE) state_next = ST_ADD_READ;
            KIND_START: if (phase == PH_IDLE) state_next = ST_RUN_READ;
            KIND_DATA: begin
              if (phase == PH_OLD) state_next = ST_RUN_VERIFY;
              else if (phase == PH_BACK) state_next = ST_RUN_READ;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_READ:   state_next = scan_end ? ST_IDLE : ST_ADD_CMP;
      ST_ADD_CMP:    state_next = hit ? ST_IDLE : ST_ADD_READ;
      ST_RUN_READ:   state_next = cur_valid ? ST_RUN_ENTRY : ST_IDLE;
      ST_RUN_ENTRY:  state_next = needs_old ? ST_IDLE : ST_RUN_VERIFY;
      ST_RUN_VERIFY: state_next = do_check ? ST_IDLE : ST_RUN_READ;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    cursor_next      = cursor;
    scan_next        = scan_idx;
    dropped_next     = dropped;
    pass_verify_next = pass_verify;
    bump             = '0;
    cnt_clear        = 1'b0;
    rd_en            = 1'b0;
    rd_idx           = cursor[IdxW-1:0];
    wr_en            = 1'b0;
    wr_idx           = scan_idx[IdxW-1:0];
    wr_data          = merged;
    item_load        = 1'b0;
    emit             = 1'b0;
    emit_op          = OP_READ;
    emit_addr        = '0;
    emit_data        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_ADD: begin
              if (phase == PH_IDLE) begin
                item_load = 1'b1;
                scan_next = '0;
              end
            end
            KIND_START: begin
              if (phase == PH_IDLE) begin
                pass_verify_next = verify_enable;
                cnt_clear        = 1'b1;
                cursor_next      = '0;
              end
            end
            KIND_DATA: begin
              if (phase == PH_OLD) begin
                if (old_diff) begin
                  emit             = 1'b1;
                  emit_op          = OP_WRITE;
                  emit_addr        = rd_data.addr;
                  emit_data        = old_val;
                  bump[CNT_WR]     = 1'b1;
                end else begin
                  bump[CNT_SKIP] = 1'b1;
                end
              end else if (phase == PH_BACK) begin
                bump[CNT_OK]  = back_ok;
                bump[CNT_BAD] = !back_ok;
                cursor_next   = cursor + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADD_READ: begin
        if (scan_end) begin
          if (full) begin
            if (dropped != DROP_MAX) dropped_next = dropped + 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_idx     = count[IdxW-1:0];
            wr_data    = item;
            count_next = count + 1'b1;
          end
        end else begin
          rd_en  = 1'b1;
          rd_idx = scan_idx[IdxW-1:0];
        end
      end
      ST_ADD_CMP: begin
        if (hit) begin
          wr_en = 1'b1;
        end else begin
          scan_next = scan_idx + 1'b1;
        end
      end
      ST_RUN_READ: begin
        if (cur_valid) begin
          rd_en = 1'b1;
        end else begin
          emit        = 1'b1;
          emit_op     = OP_FINISH;
          phase_next  = PH_IDLE;
          cursor_next = '0;
        end
      end
      ST_RUN_ENTRY: begin
        emit      = 1'b1;
        emit_addr = rd_data.addr;
        if (needs_old) begin
          emit_op    = OP_READ;
          phase_next = PH_OLD;
        end else begin
          emit_op      = OP_WRITE;
          emit_data    = rd_data.set;
          bump[CNT_WR] = 1'b1;
        end
      end
      ST_RUN_VERIFY: begin
        if (do_check) begin
          emit       = 1'b1;
          emit_op    = OP_READ;
          emit_addr  = rd_data.addr;
          phase_next = PH_BACK;
        end else begin
          bump[CNT_UNV] = pass_verify;
          cursor_next   = cursor + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_IDLE;
      count       <= '0;
      cursor      <= '0;
      scan_idx    <= '0;
      dropped     <= '0;
      pass_verify <= 1'b0;
      valid       <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      count       <= count_next;
      cursor      <= cursor_next;
      scan_idx    <= scan_next;
      dropped     <= dropped_next;
      pass_verify <= pass_verify_next;
      valid       <= emit;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= cnt_clear ? 6'd0 : cnt[i] + {5'd0, bump[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item <= item_in;
    end
    bus_op             <= emit_op;
    bus_address        <= emit_addr;
    bus_write_data     <= emit_data;
    last               <= (emit_op != OP_WRITE);
    written_count      <= (emit_op == OP_FINISH) ? cnt[CNT_WR] : 6'd0;
    skipped_count      <= (emit_op == OP_FINISH) ? cnt[CNT_SKIP] : 6'd0;
    verified_count     <= (emit_op == OP_FINISH) ? cnt[CNT_OK] : 6'd0;
    mismatched_count   <= (emit_op == OP_FINISH) ? cnt[CNT_BAD] : 6'd0;
    unverifiable_count <= (emit_op == OP_FINISH) ? cnt[CNT_UNV] : 6'd0;
    overflow_count     <= (emit_op == OP_FINISH) ? dropped : 16'd0;
  end

endmodule

### test/patch_list_monitor.sv
// Monitor for the register patch list engine: watches the request and result channels.
// Predicts every bus operation from its own copy of the patch list and compares in order.
// Depends on rple_pkg.
module patch_list_monitor #(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] reg_address,
  input  logic [31:0] clear_bits,
  input  logic [31:0] set_bits,
  input  logic [31:0] compare_mask,
  input  logic [1:0]  entry_kind,
  input  logic        multicast_flag,
  input  logic        verify_enable,
  input  logic [31:0] read_data,
  input  logic        valid,
  input  logic [1:0]  bus_op,
  input  logic [31:0] bus_address,
  input  logic [31:0] bus_write_data,
  input  logic [5:0]  written_count,
  input  logic [5:0]  skipped_count,
  input  logic [5:0]  verified_count,
  input  logic [5:0]  mismatched_count,
  input  logic [5:0]  unverifiable_count,
  input  logic [15:0] overflow_count,
  input  logic        last,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rple_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [5:0]  wr;
    logic [5:0]  skip;
    logic [5:0]  ok;
    logic [5:0]  bad;
    logic [5:0]  unv;
    logic [15:0] ovf;
    logic        last;
  } bus_result_t;

  entry_t      patch_list [LIST_DEPTH];
  int          list_len;
  int          cursor;
  logic [15:0] dropped;
  phase_t      phase;
  logic        verify_on;
  logic [5:0]  tally [NUM_CNT];
  bus_result_t expected_ops [$];
  bus_result_t item_ops [$];
  int          err_count = 0;

  task automatic push_op(input logic [1:0] op, input logic [31:0] a, input logic [31:0] d);
    bus_result_t r;
    r = '0;
    r.op = op;
    r.addr = a;
    r.wdata = d;
    if (op == OP_FINISH) begin
      r.wr   = tally[CNT_WR];
      r.skip = tally[CNT_SKIP];
      r.ok   = tally[CNT_OK];
      r.bad  = tally[CNT_BAD];
      r.unv  = tally[CNT_UNV];
      r.ovf  = dropped;
    end
    item_ops.push_back(r);
  endtask

  task automatic readback_step(output bit issued);
    issued = 1'b0;
    if (verify_on && patch_list[cursor].mask == '0) begin
      tally[CNT_UNV]++;
    end else if (verify_on) begin
      push_op(OP_READ, patch_list[cursor].addr, '0);
      phase = PH_BACK;
      issued = 1'b1;
    end
    if (!issued) cursor++;
  endtask

  task automatic walk_list();
    bit issued;
    bit stop;
    stop = 1'b0;
    while (!stop && cursor < list_len) begin
      if (patch_list[cursor].etype != ETYPE_MASKED && patch_list[cursor].clr != '0) begin
        push_op(OP_READ, patch_list[cursor].addr, '0);
        phase = PH_OLD;
        stop = 1'b1;
      end else begin
        push_op(OP_WRITE, patch_list[cursor].addr, patch_list[cursor].set);
        tally[CNT_WR]++;
        readback_step(issued);
        stop = issued;
      end
    end
    if (!stop) begin
      phase = PH_IDLE;
      cursor = 0;
      push_op(OP_FINISH, '0, '0);
    end
  endtask

  task automatic add_patch();
    logic [1:0] ek;
    bit merged;
    ek = entry_kind;
    if (ek != ETYPE_MASKED && ek != ETYPE_NOVERIFY) ek = ETYPE_PLAIN;
    merged = 1'b0;
    for (int i = 0; i < list_len && !merged; i++) begin
      if (patch_list[i].addr == reg_address && patch_list[i].mc == multicast_flag) begin
        patch_list[i].clr  = patch_list[i].clr | clear_bits;
        patch_list[i].set  = (patch_list[i].set & ~clear_bits) | set_bits;
        patch_list[i].mask = patch_list[i].mask | compare_mask;
        if (ek == ETYPE_NOVERIFY) patch_list[i].etype = ETYPE_NOVERIFY;
        merged = 1'b1;
      end
    end
    if (!merged) begin
      if (list_len >= LIST_DEPTH) begin
        if (dropped != DROP_MAX) dropped++;
      end else begin
        patch_list[list_len] = '{addr: reg_address, clr: clear_bits, set: set_bits,
                                 mask: compare_mask, etype: ek, mc: multicast_flag};
        list_len++;
      end
    end
  endtask

  task automatic predict_item();
    logic [31:0] val;
    logic [31:0] want;
    bit issued;
    item_ops.delete();
    case (kind)
      KIND_ADD: begin
        if (phase == PH_IDLE) add_patch();
      end
      KIND_START: begin
        if (phase == PH_IDLE) begin
          verify_on = verify_enable;
          foreach (tally[i]) tally[i] = '0;
          cursor = 0;
          walk_list();
        end
      end
      KIND_DATA: begin
        if (phase == PH_OLD) begin
          val = (read_data & ~patch_list[cursor].clr) | patch_list[cursor].set;
          if (val != read_data) begin
            push_op(OP_WRITE, patch_list[cursor].addr, val);
            tally[CNT_WR]++;
          end else begin
            tally[CNT_SKIP]++;
          end
          readback_step(issued);
          if (!issued) walk_list();
        end else if (phase == PH_BACK) begin
          want = patch_list[cursor].set;
          if (patch_list[cursor].etype == ETYPE_MASKED) want = want & LOW_HALF;
          if ((read_data & patch_list[cursor].mask) != (want & patch_list[cursor].mask))
            tally[CNT_BAD]++;
          else
            tally[CNT_OK]++;
          cursor++;
          walk_list();
        end
      end
      default: ;
    endcase
    if (item_ops.size() > 0) item_ops[item_ops.size() - 1].last = 1'b1;
    foreach (item_ops[i]) expected_ops.push_back(item_ops[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
    if (exp !== act) begin
      err_count++;
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  task automatic check_result();
    bus_result_t want;
    if (expected_ops.size() == 0) begin
      err_count++;
      $display("%0t: result expected none actual op %h address %h data %h",
               $time, bus_op, bus_address, bus_write_data);
    end else begin
      want = expected_ops.pop_front();
      compare_field("bus_op", 32'(want.op), 32'(bus_op));
      compare_field("bus_address", want.addr, bus_address);
      compare_field("bus_write_data", want.wdata, bus_write_data);
      compare_field("written_count", 32'(want.wr), 32'(written_count));
      compare_field("skipped_count", 32'(want.skip), 32'(skipped_count));
      compare_field("verified_count", 32'(want.ok), 32'(verified_count));
      compare_field("mismatched_count", 32'(want.bad), 32'(mismatched_count));
      compare_field("unverifiable_count", 32'(want.unv), 32'(unverifiable_count));
      compare_field("overflow_count", 32'(want.ovf), 32'(overflow_count));
      compare_field("last", 32'(want.last), 32'(last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len = 0;
      cursor = 0;
      dropped = '0;
      phase = PH_IDLE;
      verify_on = 1'b0;
      foreach (tally[i]) tally[i] = '0;
      expected_ops.delete();
    end else begin
      if (valid) check_result();
      if (start && !busy) predict_item();
    end
    errors  <= err_count;
    pending <= expected_ops.size();
  end

endmodule

### test/tb.sv
// Top of the register patch list engine testbench: clock, reset, requests and the verdict.
// Bus reads get the shadowed written value, its inverse, zeros, ones or random data.
// Depends on rple_pkg, patch_list_monitor and register_patch_list_engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rple_pkg::*;

  localparam int         DEPTH         = 32;
  localparam int         ITEM_TARGET   = 470;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES  = 80;
  localparam int         POOL_SIZE     = 20;
  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam logic [1:0] ETYPE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] clr;
    logic [31:0] set_bits;
    logic [31:0] mask;
    logic [1:0]  ek;
    logic        mc;
    logic        ve;
    logic [31:0] rd;
  } patch_req_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [31:0] reg_address;
  logic [31:0] clear_bits;
  logic [31:0] set_bits;
  logic [31:0] compare_mask;
  logic [1:0]  entry_kind;
  logic        multicast_flag;
  logic        verify_enable;
  logic [31:0] read_data;
  logic        valid;
  logic [1:0]  bus_op;
  logic [31:0] bus_address;
  logic [31:0] bus_write_data;
  logic [5:0]  written_count;
  logic [5:0]  skipped_count;
  logic [5:0]  verified_count;
  logic [5:0]  mismatched_count;
  logic [5:0]  unverifiable_count;
  logic [15:0] overflow_count;
  logic        last;
  int          fail_count;
  int          open_count;

  logic [31:0] shadow [logic [31:0]];
  logic [31:0] addr_pool [POOL_SIZE];
  int          quiet_cycles = 0;
  int          useful_sent = 0;
  bit          start_on = 1'b0;
  bit          calm = 1'b0;

  register_patch_list_engine #(.LIST_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .reg_address(reg_address), .clear_bits(clear_bits), .set_bits(set_bits),
    .compare_mask(compare_mask), .entry_kind(entry_kind), .multicast_flag(multicast_flag),
    .verify_enable(verify_enable), .read_data(read_data), .valid(valid), .bus_op(bus_op),
    .bus_address(bus_address), .bus_write_data(bus_write_data),
    .written_count(written_count), .skipped_count(skipped_count),
    .verified_count(verified_count), .mismatched_count(mismatched_count),
    .unverifiable_count(unverifiable_count), .overflow_count(overflow_count), .last(last)
  );

  patch_list_monitor #(.LIST_DEPTH(DEPTH)) mon (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .reg_address(reg_address), .clear_bits(clear_bits), .set_bits(set_bits),
    .compare_mask(compare_mask), .entry_kind(entry_kind), .multicast_flag(multicast_flag),
    .verify_enable(verify_enable), .read_data(read_data), .valid(valid), .bus_op(bus_op),
    .bus_address(bus_address), .bus_write_data(bus_write_data),
    .written_count(written_count), .skipped_count(skipped_count),
    .verified_count(verified_count), .mismatched_count(mismatched_count),
    .unverifiable_count(unverifiable_count), .overflow_count(overflow_count), .last(last),
    .errors(fail_count), .pending(open_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && valid && bus_op == OP_WRITE) shadow[bus_address] = bus_write_data;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("register_patch_list_engine verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int next_gap();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic patch_req_t rand_fields();
    patch_req_t r;
    r.kind = 2'($urandom_range(0, 3));
    r.addr = $urandom;
    r.clr = $urandom;
    r.set_bits = $urandom;
    r.mask = $urandom;
    r.ek = 2'($urandom_range(0, 3));
    r.mc = 1'($urandom_range(0, 1));
    r.ve = 1'($urandom_range(0, 1));
    r.rd = $urandom;
    return r;
  endfunction

  function automatic patch_req_t make_add(input logic [31:0] a, input logic [31:0] c,
                                          input logic [31:0] s, input logic [31:0] m,
                                          input logic [1:0] ek, input logic mc);
    patch_req_t r;
    r = rand_fields();
    r.kind = KIND_ADD;
    r.addr = a;
    r.clr = c;
    r.set_bits = s;
    r.mask = m;
    r.ek = ek;
    r.mc = mc;
    return r;
  endfunction

  function automatic patch_req_t rand_add();
    patch_req_t r;
    r = rand_fields();
    r.kind = KIND_ADD;
    if ($urandom_range(0, 9) != 0) r.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    case ($urandom_range(0, 3))
      0: r.clr = '0;
      1: r.clr = 32'hff << (8 * $urandom_range(0, 3));
      2: r.clr = '1;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: r.mask = '0;
      1: r.mask = r.clr | r.set_bits;
      2: r.mask = '1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic patch_req_t noise_req(input bit in_pass);
    patch_req_t r;
    r = rand_fields();
    if (in_pass) begin
      case ($urandom_range(0, 2))
        0: r.kind = KIND_ADD;
        1: r.kind = KIND_START;
        default: r.kind = KIND_NONE;
      endcase
    end else begin
      r.kind = $urandom_range(0, 1) ? KIND_DATA : KIND_NONE;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_read(input logic [31:0] a);
    int pick;
    pick = $urandom_range(0, 9);
    if (shadow.exists(a) && pick < 6) return shadow[a];
    if (shadow.exists(a) && pick == 6) return ~shadow[a];
    if (pick == 7) return '0;
    if (pick == 8) return '1;
    return $urandom;
  endfunction

  task automatic send_item(input patch_req_t r, input int gap, input bit useful);
    if (gap > 0) begin
      if (start_on) begin
        start <= 1'b0;
        start_on = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    kind <= r.kind;
    reg_address <= r.addr;
    clear_bits <= r.clr;
    set_bits <= r.set_bits;
    compare_mask <= r.mask;
    entry_kind <= r.ek;
    multicast_flag <= r.mc;
    verify_enable <= r.ve;
    read_data <= r.rd;
    start <= 1'b1;
    start_on = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (useful) useful_sent++;
  endtask

  task automatic release_start();
    if (start_on) begin
      start <= 1'b0;
      start_on = 1'b0;
    end
  endtask

  // Runs one apply pass to its finish, answering each bus read as it comes.
  task automatic run_pass(input bit ve, input bit loud);
    patch_req_t r;
    logic [31:0] rd_addr;
    bit done;
    r = rand_fields();
    r.kind = KIND_START;
    r.ve = ve;
    send_item(r, next_gap(), 1'b1);
    release_start();
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (valid && last) begin
        if (bus_op == OP_READ) begin
          rd_addr = bus_address;
          if (loud || $urandom_range(0, 7) == 0)
            repeat (loud ? 3 : 1) send_item(noise_req(1'b1), next_gap(), 1'b0);
          r = rand_fields();
          r.kind = KIND_DATA;
          r.rd = pick_read(rd_addr);
          send_item(r, next_gap(), 1'b1);
          release_start();
        end else begin
          done = 1'b1;
        end
      end
    end
  endtask

  initial begin
    patch_req_t r;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_ADD;
    reg_address <= '0;
    clear_bits <= '0;
    set_bits <= '0;
    compare_mask <= '0;
    entry_kind <= ETYPE_PLAIN;
    multicast_flag <= 1'b0;
    verify_enable <= 1'b0;
    read_data <= '0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom & 32'h0003_fffc;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = 32'h0000_0100;
    addr_pool[3] = 32'h0000_0200;
    addr_pool[4] = 32'h0000_0300;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty list, stray data, unknown kinds, merges, then full passes.
    run_pass(1'b0, 1'b0);
    r = rand_fields();
    r.kind = KIND_DATA;
    r.rd = '1;
    send_item(r, next_gap(), 1'b0);
    r.rd = '0;
    send_item(r, next_gap(), 1'b0);
    r.kind = KIND_NONE;
    send_item(r, next_gap(), 1'b0);
    send_item(make_add(32'h0, 32'h0, '1, '1, ETYPE_PLAIN, 1'b0), next_gap(), 1'b1);
    send_item(make_add('1, '1, 32'h0, 32'h0, ETYPE_PLAIN, 1'b1), next_gap(), 1'b1);
    send_item(make_add(32'h100, 32'hffff_0000, 32'h1234, '1, ETYPE_MASKED, 1'b0),
              next_gap(), 1'b1);
    send_item(make_add(32'h200, 32'hf, 32'h5, 32'hf, ETYPE_NOVERIFY, 1'b0), next_gap(), 1'b1);
    send_item(make_add(32'h300, 32'hff, 32'ha5, 32'hff, ETYPE_UNKNOWN, 1'b1), next_gap(), 1'b1);
    send_item(make_add(32'h100, 32'h1, 32'h2, 32'h0, ETYPE_NOVERIFY, 1'b0), next_gap(), 1'b1);
    send_item(make_add(32'h300, 32'hff00, 32'h5a00, 32'h0, ETYPE_MASKED, 1'b1),
              next_gap(), 1'b1);
    send_item(make_add(32'h0, 32'h0, 32'h0, 32'h0, ETYPE_PLAIN, 1'b1), next_gap(), 1'b1);
    run_pass(1'b1, 1'b1);
    run_pass(1'b1, 1'b0);
    run_pass(1'b0, 1'b0);

    while (useful_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      case ($urandom_range(0, 99)) inside
        [0:69]:  send_item(rand_add(), next_gap(), 1'b1);
        [70:81]: run_pass(1'($urandom_range(0, 1)), 1'b0);
        default: send_item(noise_req(1'b0), next_gap(), 1'b0);
      endcase
    end
    release_start();

    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("register_patch_list_engine verification clean");
    end else begin
      $display("register_patch_list_engine verification failed");
    end
    $finish;
  end

endmodule

### register_patch_list_engine.f
hw/rtl/rple_pkg.sv
hw/rtl/register_patch_list_engine.sv
test/patch_list_monitor.sv
test/tb.sv
